### sv/ilc_pkg.sv
package ilc_pkg;

  localparam int ILC_MAX_CONTENT = 255;

  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_TYP   = 3'd1;
  localparam logic [2:0] KIND_DTO   = 3'd2;
  localparam logic [2:0] KIND_NON   = 3'd3;
  localparam logic [2:0] KIND_FAULT = 3'd4;

  localparam logic [7:0] DESC_SPACES      = 8'd4;
  localparam logic [7:0] FAULT_MIN_SPACES = 8'd6;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_start;
    logic       typ_wanted;
    logic       dto_wanted;
    logic       non_wanted;
    logic       fault_wanted;
  } ilc_item_t;

  typedef struct packed {
    logic [2:0] token_kind;
    logic [7:0] space_count;
    logic [7:0] content_length;
  } ilc_result_t;

endpackage

### sv/ilc_in_stage.sv
module ilc_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ilc_pkg::ilc_item_t   in_item,
  input  logic                 step,
  output logic                 item_valid,
  output ilc_pkg::ilc_item_t   item
);
  import ilc_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  ilc_item_t item_r;

  // The held word leaves on a step, so a new one may enter in the same cycle.
  assign in_ready   = !valid_r || step;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (step) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

### sv/ilc_scan_core.sv
module ilc_scan_core #(
  parameter int MAX_CONTENT = ilc_pkg::ILC_MAX_CONTENT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  ilc_pkg::ilc_item_t    item,
  output logic                  res_valid,
  output ilc_pkg::ilc_result_t  res
);
  import ilc_pkg::*;

  localparam int CNT_W = $clog2(MAX_CONTENT + 1);
  localparam int LEN_W = (CNT_W > 8) ? CNT_W : 8;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_SPACES = 2'd1;
  localparam logic [1:0] PH_FAULT  = 2'd2;
  localparam logic [1:0] PH_DESC   = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DASH  = 8'h2D;

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // Characters of the "return(" prefix by position.
  function automatic logic [7:0] ret_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h72;
      3'd1:    c = 8'h65;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h75;
      3'd4:    c = 8'h72;
      3'd5:    c = 8'h6E;
      3'd6:    c = CH_OPEN;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  logic [1:0]       phase_r,  phase_nxt;
  logic [7:0]       spaces_r, spaces_nxt;
  logic [CNT_W-1:0] cnt_r,    cnt_nxt;
  logic [3:0]       wanted_r, wanted_nxt;
  logic             fault_ok_r, fault_ok_nxt;
  logic             dot_r,    dot_nxt;
  logic             code_r,   code_nxt;
  logic             prefix_r, prefix_nxt;

  logic             emit;
  logic             finish;
  logic             take;
  logic [2:0]       kind;
  logic [LEN_W-1:0] cnt_ext;
  logic [7:0]       ch;

  assign ch = item.ch;

  always_comb begin
    phase_nxt    = phase_r;
    spaces_nxt   = spaces_r;
    cnt_nxt      = cnt_r;
    wanted_nxt   = wanted_r;
    fault_ok_nxt = fault_ok_r;
    dot_nxt      = dot_r;
    code_nxt     = code_r;
    prefix_nxt   = prefix_r;
    emit         = 1'b0;
    finish       = 1'b0;
    take         = 1'b0;
    kind         = KIND_NONE;

    if (item.line_start) begin
      spaces_nxt   = '0;
      cnt_nxt      = '0;
      fault_ok_nxt = 1'b1;
      dot_nxt      = 1'b0;
      code_nxt     = 1'b0;
      prefix_nxt   = 1'b1;
      wanted_nxt   = {item.fault_wanted, item.non_wanted,
                      item.dto_wanted, item.typ_wanted};
      phase_nxt    = (wanted_nxt == 4'd0) ? PH_IDLE : PH_SPACES;
      emit         = (wanted_nxt == 4'd0);
    end

    if (!emit) begin
      unique case (phase_nxt)
        PH_IDLE: begin
        end
        PH_SPACES: begin
          priority if (ch == CH_SPACE) begin
            if (spaces_nxt != 8'hFF) begin
              spaces_nxt = spaces_nxt + 8'd1;
            end
          end else if (wanted_nxt[3] && (spaces_nxt >= FAULT_MIN_SPACES)) begin
            if (!is_lower(ch)) begin
              emit = 1'b1;
            end else begin
              phase_nxt = PH_FAULT;
              take      = 1'b1;
            end
          end else if ((spaces_nxt != DESC_SPACES) || (wanted_nxt[2:0] == 3'd0) ||
                       !is_lower(ch)) begin
            emit = 1'b1;
          end else begin
            phase_nxt = PH_DESC;
            take      = 1'b1;
          end
        end
        default: begin
          if ((ch == CH_LF) || (ch == CH_CR) || (ch == CH_NUL)) begin
            finish = 1'b1;
          end else begin
            take = 1'b1;
          end
        end
      endcase
    end

    if (take) begin
      if (phase_nxt == PH_FAULT) begin
        if (!(is_lower(ch) || is_digit(ch) || (ch == CH_DASH) || (ch == CH_SPACE))) begin
          fault_ok_nxt = 1'b0;
        end
      end else begin
        if ((cnt_nxt == CNT_W'(2)) && (ch == CH_COLON)) begin
          code_nxt = 1'b1;
        end
        if (cnt_nxt < CNT_W'(7)) begin
          if (ch != ret_char(cnt_nxt[2:0])) begin
            prefix_nxt = 1'b0;
          end else if ((cnt_nxt == CNT_W'(6)) && prefix_nxt) begin
            code_nxt = 1'b1;
          end
        end
        // The dot test uses the flag as it stood before this character.
        priority if (ch == CH_DOT) begin
          dot_nxt = 1'b1;
        end else if ((ch == CH_OPEN) && dot_nxt) begin
          code_nxt = 1'b1;
        end else if ((ch == CH_COLON) && !dot_nxt) begin
          code_nxt = 1'b1;
        end else begin
        end
      end
      cnt_nxt = cnt_nxt + CNT_W'(1);
      if (cnt_nxt >= CNT_W'(MAX_CONTENT)) begin
        finish = 1'b1;
      end
    end

    if (finish) begin
      emit = 1'b1;
      priority if (phase_nxt == PH_FAULT) begin
        kind = fault_ok_nxt ? KIND_FAULT : KIND_NONE;
      end else if (code_nxt) begin
        kind = KIND_NONE;
      end else if (wanted_nxt[0]) begin
        kind = KIND_TYP;
      end else if (wanted_nxt[1]) begin
        kind = KIND_DTO;
      end else begin
        kind = KIND_NON;
      end
    end

    if (emit) begin
      phase_nxt = PH_IDLE;
    end
  end

  assign cnt_ext = LEN_W'(cnt_nxt);

  assign res_valid          = step && emit;
  assign res.token_kind     = kind;
  assign res.space_count    = spaces_nxt;
  assign res.content_length = (cnt_ext > LEN_W'(255)) ? 8'hFF : cnt_ext[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      spaces_r   <= '0;
      cnt_r      <= '0;
      wanted_r   <= '0;
      fault_ok_r <= 1'b1;
      dot_r      <= 1'b0;
      code_r     <= 1'b0;
      prefix_r   <= 1'b1;
    end else if (step) begin
      phase_r    <= phase_nxt;
      spaces_r   <= spaces_nxt;
      cnt_r      <= cnt_nxt;
      wanted_r   <= wanted_nxt;
      fault_ok_r <= fault_ok_nxt;
      dot_r      <= dot_nxt;
      code_r     <= code_nxt;
      prefix_r   <= prefix_nxt;
    end
  end

endmodule

### sv/ilc_out_stage.sv
module ilc_out_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  ilc_pkg::ilc_result_t  res,
  output logic                  room,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ilc_pkg::ilc_result_t  out_res
);
  import ilc_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  ilc_result_t res_r;

  assign room      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

### sv/indented_line_classifier.sv
// Channel  Handshake              Word
// in_      in_valid / in_ready    ch, line_start, four *_wanted flags
// out_     out_valid / out_ready  token_kind, space_count, content_length
//
// One character per cycle. A character is held in the input register and its
// result, if any, is loaded into the output register by the step that takes it.
// A step of the scan logic needs room in the output register, so a stalled
// output holds back the input register and then in_ready.
// Synchronous active-low reset returns the scanner to idle and empties both
// registers.
module indented_line_classifier #(
  parameter int MAX_CONTENT = ilc_pkg::ILC_MAX_CONTENT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_line_start,
  input  logic       in_typ_wanted,
  input  logic       in_dto_wanted,
  input  logic       in_non_wanted,
  input  logic       in_fault_wanted,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_token_kind,
  output logic [7:0] out_space_count,
  output logic [7:0] out_content_length
);
  import ilc_pkg::*;

  ilc_item_t   in_item;
  ilc_item_t   item;
  logic        item_valid;
  logic        step;
  logic        room;
  logic        res_valid;
  ilc_result_t res;
  ilc_result_t out_res;

  assign in_item.ch           = in_ch;
  assign in_item.line_start   = in_line_start;
  assign in_item.typ_wanted   = in_typ_wanted;
  assign in_item.dto_wanted   = in_dto_wanted;
  assign in_item.non_wanted   = in_non_wanted;
  assign in_item.fault_wanted = in_fault_wanted;

  assign step = item_valid && room;

  ilc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .step       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  ilc_scan_core #(
    .MAX_CONTENT (MAX_CONTENT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  ilc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_token_kind     = out_res.token_kind;
  assign out_space_count    = out_res.space_count;
  assign out_content_length = out_res.content_length;

  // A description is only ever taken after exactly four spaces.
  a_desc_spaces: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind == KIND_TYP || out_token_kind == KIND_DTO ||
                  out_token_kind == KIND_NON)
    |-> out_space_count == DESC_SPACES && out_content_length != 8'd0)
    else $error("description word without four spaces or content");

  // A fault line needs at least six spaces and a first letter.
  a_fault_spaces: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == KIND_FAULT
    |-> out_space_count >= FAULT_MIN_SPACES && out_content_length != 8'd0)
    else $error("fault line word with too few spaces or no content");

  // A result is only loaded from a step of the scanner.
  a_load_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> item_valid && room)
    else $error("result produced without a held character");

endmodule

### test/tb_indented_line_classifier.sv
`timescale 1ns / 1ps

module tb_indented_line_classifier;
  import ilc_pkg::*;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam string RETURN_OPEN = "return(";

  localparam int WANT_TYP   = 0;
  localparam int WANT_DTO   = 1;
  localparam int WANT_NON   = 2;
  localparam int WANT_FAULT = 3;

  localparam logic [3:0] ASK_NONE  = 4'b0000;
  localparam logic [3:0] ASK_TYP   = 4'b0001;
  localparam logic [3:0] ASK_DTO   = 4'b0010;
  localparam logic [3:0] ASK_NON   = 4'b0100;
  localparam logic [3:0] ASK_FAULT = 4'b1000;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_SPACES, SCAN_FAULT, SCAN_DESC} scan_phase_t;

  typedef struct {
    ilc_item_t   w;
    bit          typed;
    ilc_result_t due;
  } table_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_ch;
  logic       in_line_start;
  logic       in_typ_wanted;
  logic       in_dto_wanted;
  logic       in_non_wanted;
  logic       in_fault_wanted;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] out_token_kind;
  logic [7:0] out_space_count;
  logic [7:0] out_content_length;

  indented_line_classifier uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_ch(in_ch),
    .in_line_start(in_line_start),
    .in_typ_wanted(in_typ_wanted),
    .in_dto_wanted(in_dto_wanted),
    .in_non_wanted(in_non_wanted),
    .in_fault_wanted(in_fault_wanted),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_token_kind(out_token_kind),
    .out_space_count(out_space_count),
    .out_content_length(out_content_length)
  );

  // Scanner state mirrored by the line classifier below.
  scan_phase_t scan_phase = SCAN_IDLE;
  logic [7:0]  lead_spaces = '0;
  int          col_count = 0;
  logic [3:0]  want = '0;
  bit          fault_clean = 1'b1;
  bit          dot_found = 1'b0;
  bit          code_seen = 1'b0;
  bit          return_match = 1'b1;

  ilc_result_t due_results[$];
  ilc_result_t oldest_due;
  ilc_item_t   line_words[$];
  table_row_t  dir_rows[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  int scan_words = 0;
  int words_sent = 0;
  int results_checked = 0;
  int kind_tally[5] = '{0, 0, 0, 0, 0};

  function automatic bit is_lower(logic [7:0] c);
    return c >= "a" && c <= "z";
  endfunction

  function automatic ilc_item_t make_word(logic [7:0] c, logic ls, logic [3:0] flags);
    return '{c, ls, flags[WANT_TYP], flags[WANT_DTO], flags[WANT_NON], flags[WANT_FAULT]};
  endfunction

  function automatic logic [2:0] scan_kind();
    if (scan_phase == SCAN_FAULT) return fault_clean ? KIND_FAULT : KIND_NONE;
    if (code_seen) return KIND_NONE;
    if (want[WANT_TYP]) return KIND_TYP;
    if (want[WANT_DTO]) return KIND_DTO;
    return KIND_NON;
  endfunction

  task automatic take_char(input logic [7:0] c);
    int pos;
    pos = col_count;
    if (scan_phase == SCAN_FAULT) begin
      if (!(is_lower(c) || (c >= "0" && c <= "9") || c == "-" || c == " "))
        fault_clean = 1'b0;
    end else begin
      if (pos == 2 && c == ":") code_seen = 1'b1;
      if (pos < 7) begin
        if (c != RETURN_OPEN[pos]) return_match = 1'b0;
        else if (pos == 6 && return_match) code_seen = 1'b1;
      end
      if (c == ".") dot_found = 1'b1;
      else if (c == "(" && dot_found) code_seen = 1'b1;
      else if (c == ":" && !dot_found) code_seen = 1'b1;
    end
    col_count = pos + 1;
  endtask

  // Advances the mirrored scanner by one word and reports the result it yields.
  task automatic classify_word(input ilc_item_t w, output bit has_res,
                               output ilc_result_t res, output bit in_scan);
    logic [7:0] c;
    logic [2:0] kind;
    bit done;
    c = w.ch;
    kind = KIND_NONE;
    done = 1'b0;
    in_scan = w.line_start || scan_phase != SCAN_IDLE;
    if (w.line_start) begin
      scan_phase = SCAN_IDLE;
      lead_spaces = '0;
      col_count = 0;
      fault_clean = 1'b1;
      dot_found = 1'b0;
      code_seen = 1'b0;
      return_match = 1'b1;
      want = {w.fault_wanted, w.non_wanted, w.dto_wanted, w.typ_wanted};
      if (want == ASK_NONE) done = 1'b1;
      else scan_phase = SCAN_SPACES;
    end
    if (!done && scan_phase == SCAN_SPACES) begin
      if (c == " ") begin
        if (lead_spaces != 8'hFF) lead_spaces++;
      end else if (want[WANT_FAULT] && lead_spaces >= FAULT_MIN_SPACES) begin
        if (!is_lower(c)) done = 1'b1;
        else begin
          scan_phase = SCAN_FAULT;
          take_char(c);
        end
      end else if (lead_spaces != DESC_SPACES || want[2:0] == 3'b000 || !is_lower(c)) begin
        done = 1'b1;
      end else begin
        scan_phase = SCAN_DESC;
        take_char(c);
      end
    end else if (!done && scan_phase != SCAN_IDLE) begin
      // Line endings close the scan without being counted as content.
      if (c == CH_LF || c == CH_CR || c == CH_NUL) begin
        kind = scan_kind();
        done = 1'b1;
      end else begin
        take_char(c);
      end
    end
    if (!done && (scan_phase == SCAN_FAULT || scan_phase == SCAN_DESC) &&
        col_count >= ILC_MAX_CONTENT) begin
      kind = scan_kind();
      done = 1'b1;
    end
    has_res = done;
    res.token_kind = kind;
    res.space_count = lead_spaces;
    res.content_length = (col_count > 255) ? 8'd255 : col_count[7:0];
    if (done) scan_phase = SCAN_IDLE;
  endtask

  task automatic add_row(input logic [7:0] c, input logic ls, input logic [3:0] flags,
                         input bit typed, input ilc_result_t due);
    table_row_t row;
    row.w = make_word(c, ls, flags);
    row.typed = typed;
    row.due = due;
    dir_rows.push_back(row);
  endtask

  task automatic send_word(input ilc_item_t w, input bit typed, input ilc_result_t due);
    bit has_res;
    bit in_scan;
    ilc_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_ch <= w.ch;
    in_line_start <= w.line_start;
    in_typ_wanted <= w.typ_wanted;
    in_dto_wanted <= w.dto_wanted;
    in_non_wanted <= w.non_wanted;
    in_fault_wanted <= w.fault_wanted;
    do @(posedge clk); while (!in_ready);
    classify_word(w, has_res, res, in_scan);
    if (has_res) due_results.push_back(typed ? due : res);
    if (in_scan) scan_words++;
    words_sent++;
  endtask

  task automatic settle_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  function automatic void add_char(logic [7:0] c, logic [3:0] flags);
    line_words.push_back(make_word(c, line_words.size() == 0, flags));
  endfunction

  // Recipe 1 opens with "return(", recipe 2 with "return" only, recipe 3 puts a
  // colon at the third position.
  task automatic add_body(input int n, input bit tricky, input int recipe,
                          input logic [3:0] flags);
    int pick;
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (recipe == 1 && i < 7) c = RETURN_OPEN[i];
      else if (recipe == 2 && i < 6) c = RETURN_OPEN[i];
      else if (recipe == 3 && i == 2) c = ":";
      else if (i == 0) c = (pick < 90) ? 8'("a" + $urandom_range(25)) : 8'($urandom_range(255));
      else if (tricky && pick < 7) c = ".";
      else if (tricky && pick < 12) c = ":";
      else if (tricky && pick < 17) c = "(";
      else if (tricky && pick < 20) c = 8'($urandom_range(255));
      else if (pick < 75) c = 8'("a" + $urandom_range(25));
      else if (pick < 85) c = 8'("0" + $urandom_range(9));
      else if (pick < 93) c = " ";
      else c = "-";
      add_char(c, flags);
    end
  endtask

  task automatic random_line();
    int shape;
    int n_sp;
    int n_body;
    int pick;
    logic [3:0] flags;
    shape = $urandom_range(99);
    flags = 4'($urandom_range(15));
    line_words.delete();
    n_body = ($urandom_range(39) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 16);
    if (shape < 80) begin
      if (shape < 45) begin
        if (flags[2:0] == 3'b000) flags[$urandom_range(2)] = 1'b1;
        n_sp = ($urandom_range(9) == 0) ? $urandom_range(8) : 4;
      end else begin
        flags[WANT_FAULT] = 1'b1;
        pick = $urandom_range(15);
        if (pick == 0) n_sp = $urandom_range(250, 300);
        else if (pick == 1) n_sp = $urandom_range(5);
        else n_sp = $urandom_range(6, 10);
      end
      repeat (n_sp) add_char(" ", flags);
      add_body(n_body, $urandom_range(99) < ((shape < 45) ? 50 : 30),
               (shape < 45) ? $urandom_range(5) : 0, flags);
      pick = $urandom_range(9);
      if (pick < 3) add_char(CH_LF, flags);
      else if (pick < 6) add_char(CH_CR, flags);
      else if (pick < 8) add_char(CH_NUL, flags);
    end else begin
      // Noise: stray bytes, now and then with a line start of random flags.
      repeat ($urandom_range(1, 8))
        line_words.push_back(make_word(8'($urandom_range(255)),
                                       shape < 92 && $urandom_range(3) == 0,
                                       4'($urandom_range(15))));
    end
  endtask

  task automatic run_random(input int n_words);
    int start;
    start = words_sent;
    while (words_sent - start < n_words) begin
      random_line();
      foreach (line_words[i]) send_word(line_words[i], 1'b0, '0);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected word, kind %0d spaces %0d length %0d", $time,
                 out_token_kind, out_space_count, out_content_length);
        fail_count++;
      end else begin
        oldest_due = due_results.pop_front();
        results_checked++;
        if (out_token_kind < 5) kind_tally[out_token_kind]++;
        if (out_token_kind !== oldest_due.token_kind) begin
          $display("%0t: token_kind expected %0d actual %0d", $time,
                   oldest_due.token_kind, out_token_kind);
          fail_count++;
        end
        if (out_space_count !== oldest_due.space_count) begin
          $display("%0t: space_count expected %0d actual %0d", $time,
                   oldest_due.space_count, out_space_count);
          fail_count++;
        end
        if (out_content_length !== oldest_due.content_length) begin
          $display("%0t: content_length expected %0d actual %0d", $time,
                   oldest_due.content_length, out_content_length);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_ch = '0;
    in_line_start = 1'b0;
    in_typ_wanted = 1'b0;
    in_dto_wanted = 1'b0;
    in_non_wanted = 1'b0;
    in_fault_wanted = 1'b0;

    // Nothing wanted, then a byte with every bit and every flag set.
    add_row("a", 1'b1, ASK_NONE, 1'b1, '{KIND_NONE, 8'd0, 8'd0});
    add_row(8'hFF, 1'b1, 4'hF, 1'b1, '{KIND_NONE, 8'd0, 8'd0});
    // Description with a colon at the third position reads as code.
    add_row(" ", 1'b1, ASK_TYP | ASK_DTO | ASK_NON, 1'b0, '0);
    repeat (3) add_row(" ", 1'b0, ASK_NONE, 1'b0, '0);
    add_row("r", 1'b0, ASK_NONE, 1'b0, '0);
    add_row("e", 1'b0, ASK_NONE, 1'b0, '0);
    add_row(":", 1'b0, ASK_NONE, 1'b0, '0);
    add_row(CH_NUL, 1'b0, ASK_NONE, 1'b1, '{KIND_NONE, 8'd4, 8'd3});
    // A new line start drops the open scan; the stray byte after it is ignored.
    add_row(" ", 1'b1, ASK_FAULT, 1'b0, '0);
    add_row("q", 1'b1, ASK_NONE, 1'b1, '{KIND_NONE, 8'd0, 8'd0});
    add_row("x", 1'b0, ASK_NONE, 1'b0, '0);
    // Clean fault line closed by a carriage return.
    add_row(" ", 1'b1, ASK_FAULT | ASK_TYP, 1'b0, '0);
    repeat (5) add_row(" ", 1'b0, ASK_NONE, 1'b0, '0);
    add_row("z", 1'b0, ASK_NONE, 1'b0, '0);
    add_row("-", 1'b0, ASK_NONE, 1'b0, '0);
    add_row("9", 1'b0, ASK_NONE, 1'b0, '0);
    add_row(CH_CR, 1'b0, ASK_NONE, 1'b0, '0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 15;
    recv_idle_pct = 64;
    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].due);
    run_random(300);
    settle_results();

    send_idle_pct = 64;
    recv_idle_pct = 15;
    run_random(300);
    settle_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(300);
    settle_results();
    repeat (10) @(posedge clk);

    $display("Sent %0d words, %0d inside scans, under three idle mixes; %0d results checked",
             words_sent, scan_words, results_checked);
    $display("Kinds seen: none %0d, typ %0d, dto %0d, non %0d, fault %0d",
             kind_tally[0], kind_tally[1], kind_tally[2], kind_tally[3], kind_tally[4]);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
